[rtl/urfd_pkg.sv]
`default_nettype none

package urfd_pkg;

  // Frame geometry
  localparam int unsigned FRAME_BYTES = 20;
  localparam int unsigned TAIL_BYTES  = 4;
  // Frame bytes 1 to 15 travel to the back end; byte k sits at body index k-1
  localparam int unsigned BODY_BYTES  = 15;
  localparam int unsigned SUM_BYTES   = 14;
  localparam int unsigned CNT_W       = 5;
  localparam int unsigned CFG_IDX_W   = 4;
  localparam int unsigned CFG_DATA_W  = 32;

  // Register reset values
  localparam logic [7:0]  HEADER_RESET = 8'hFD;
  localparam logic [31:0] TAIL_RESET   = 32'h55AA33CC;

  // Body positions (frame byte minus one)
  localparam int unsigned POS_COMMAND  = 0;
  localparam int unsigned POS_STATUS   = 1;
  localparam int unsigned POS_FRONT    = 1;
  localparam int unsigned POS_BACK     = 9;
  localparam int unsigned POS_PARAM    = 13;
  localparam int unsigned POS_CHECKSUM = 14;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_EXPECTED_HEADER = 4'd0,
    CFG_TAIL_PATTERN    = 4'd1
  } cfg_idx_e;

  typedef logic [BODY_BYTES-1:0][7:0] body_t;

  // Queue status seen by both ends
  typedef struct packed {
    logic full;
    logic empty;
  } queue_stat_t;

endpackage

`default_nettype wire

[rtl/urfd_queue.sv]
`default_nettype none

module urfd_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  push_i,
  input  urfd_pkg::body_t      push_data_i,
  input  wire                  pop_i,
  output urfd_pkg::body_t      head_o,
  output urfd_pkg::queue_stat_t stat_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  urfd_pkg::body_t  mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  assign stat_o.full  = (cnt_q == FULL_CNT);
  assign stat_o.empty = (cnt_q == '0);
  assign head_o       = mem_q[rd_ptr_q];

  // Pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push_i && pop_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Storage, no reset
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

[rtl/urfd_front.sv]
`default_nettype none

module urfd_front (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  // byte input
  input  wire                               rx_valid_i,
  output logic                              rx_ready_o,
  input  wire  [7:0]                        rx_byte_i,
  // configuration writes
  input  wire                               cfg_valid_i,
  output logic                              cfg_ready_o,
  input  wire  [urfd_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  wire  [urfd_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  // queue side
  input  urfd_pkg::queue_stat_t             q_stat_i,
  output logic                              push_o,
  output urfd_pkg::body_t                   push_data_o
);

  localparam int unsigned FB = urfd_pkg::FRAME_BYTES;
  localparam int unsigned TB = urfd_pkg::TAIL_BYTES;
  localparam logic [urfd_pkg::CNT_W-1:0] CNT_FULL = urfd_pkg::CNT_W'(FB);
  localparam logic [urfd_pkg::CNT_W-1:0] CNT_TAIL = urfd_pkg::CNT_W'(TB);

  logic [7:0]                 hdr_q;
  logic [31:0]                tail_q;
  logic [7:0]                 win_q [FB];
  logic [7:0]                 win_d [FB];
  logic [urfd_pkg::CNT_W-1:0] cnt_q, cnt_d, cnt_inc;
  logic                       rx_take;
  logic                       tail_hit;
  logic [31:0]                last4;

  assign cfg_ready_o = 1'b1;
  assign rx_ready_o  = !q_stat_i.full;
  assign rx_take     = rx_valid_i && rx_ready_o;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_q  <= urfd_pkg::HEADER_RESET;
      tail_q <= urfd_pkg::TAIL_RESET;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == urfd_pkg::CFG_EXPECTED_HEADER) begin
        hdr_q <= cfg_data_i[7:0];
      end else if (cfg_index_i == urfd_pkg::CFG_TAIL_PATTERN) begin
        tail_q <= cfg_data_i;
      end
    end
  end

  // Window after the shift: entry 0 oldest
  always_comb begin
    for (int i = 0; i < FB - 1; i++) begin
      win_d[i] = win_q[i+1];
    end
    win_d[FB-1] = rx_byte_i;
  end

  assign cnt_inc  = (cnt_q < CNT_FULL) ? cnt_q + 1'b1 : cnt_q;
  assign last4    = {win_d[FB-4], win_d[FB-3], win_d[FB-2], win_d[FB-1]};
  assign tail_hit = (cnt_inc >= CNT_TAIL) && (last4 == tail_q);

  // Boundary tracking and frame push
  always_comb begin
    cnt_d  = cnt_q;
    push_o = 1'b0;
    if (rx_take) begin
      cnt_d = cnt_inc;
      if (tail_hit) begin
        cnt_d  = '0;
        push_o = (cnt_inc == CNT_FULL) && (win_d[0] == hdr_q);
      end
    end
  end

  always_comb begin
    for (int k = 0; k < urfd_pkg::BODY_BYTES; k++) begin
      push_data_o[k] = win_d[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  // Byte window, no reset needed: a frame only reads bytes since the boundary
  always_ff @(posedge clk_i) begin
    if (rx_take) begin
      win_q <= win_d;
    end
  end

endmodule

`default_nettype wire

[rtl/urfd_back.sv]
`default_nettype none

module urfd_back (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  // queue side
  input  urfd_pkg::queue_stat_t q_stat_i,
  input  urfd_pkg::body_t       head_i,
  output logic                  pop_o,
  // result output
  output logic                  res_valid_o,
  input  wire                   res_ready_i,
  output logic [7:0]            command_code_o,
  output logic [7:0]            status_code_o,
  output logic [7:0]            param_status_o,
  output logic [63:0]           payload_front_o,
  output logic [31:0]           payload_back_o,
  output logic [7:0]            received_checksum_o,
  output logic                  checksum_ok_o
);

  localparam int unsigned PAIRS = urfd_pkg::SUM_BYTES / 2;

  logic       valid_q;
  logic [7:0] pair_sum [PAIRS];
  logic [7:0] sum;
  logic [7:0] cmd_q, sts_q, prm_q, rck_q;
  logic [63:0] pf_q;
  logic [31:0] pb_q;
  logic        ok_q;

  assign pop_o = !q_stat_i.empty && (!valid_q || res_ready_i);

  // Checksum of frame bytes 1..14: pair sums, then a short chain
  always_comb begin
    for (int j = 0; j < PAIRS; j++) begin
      pair_sum[j] = head_i[2*j] + head_i[2*j+1];
    end
    sum = '0;
    for (int j = 0; j < PAIRS; j++) begin
      sum = sum + pair_sum[j];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (pop_o) begin
      valid_q <= 1'b1;
    end else if (res_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  // Result register
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cmd_q <= head_i[urfd_pkg::POS_COMMAND];
      sts_q <= head_i[urfd_pkg::POS_STATUS];
      prm_q <= head_i[urfd_pkg::POS_PARAM];
      rck_q <= head_i[urfd_pkg::POS_CHECKSUM];
      for (int k = 0; k < 8; k++) begin
        pf_q[63-8*k -: 8] <= head_i[urfd_pkg::POS_FRONT + k];
      end
      for (int k = 0; k < 4; k++) begin
        pb_q[31-8*k -: 8] <= head_i[urfd_pkg::POS_BACK + k];
      end
      ok_q <= (sum == head_i[urfd_pkg::POS_CHECKSUM]);
    end
  end

  assign res_valid_o         = valid_q;
  assign command_code_o      = cmd_q;
  assign status_code_o       = sts_q;
  assign param_status_o      = prm_q;
  assign payload_front_o     = pf_q;
  assign payload_back_o      = pb_q;
  assign received_checksum_o = rck_q;
  assign checksum_ok_o       = ok_q;

endmodule

`default_nettype wire

[rtl/uart_response_frame_deframer.sv]
`default_nettype none

// Channel   Handshake                 Payload
// rx        rx_valid_i / rx_ready_o   rx_byte_i
// cfg       cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
// res       res_valid_o / res_ready_i command_code_o .. checksum_ok_o
//
// One byte per cycle while rx_ready_o is high; a frame result passes through the
// queue and then the result register after its last tail byte.
// rx_ready_o drops only while the frame queue (QUEUE_DEPTH entries) is full.
// Reset clears the boundary count, queue and result valid; registers load
// their defaults. cfg_ready_o is always high.
module uart_response_frame_deframer #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  wire                             clk_i,
  input  wire                             rst_ni,
  input  wire                             rx_valid_i,
  output logic                            rx_ready_o,
  input  wire  [7:0]                      rx_byte_i,
  input  wire                             cfg_valid_i,
  output logic                            cfg_ready_o,
  input  wire  [urfd_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire  [urfd_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output logic                            res_valid_o,
  input  wire                             res_ready_i,
  output logic [7:0]                      command_code_o,
  output logic [7:0]                      status_code_o,
  output logic [7:0]                      param_status_o,
  output logic [63:0]                     payload_front_o,
  output logic [31:0]                     payload_back_o,
  output logic [7:0]                      received_checksum_o,
  output logic                            checksum_ok_o
);

  urfd_pkg::queue_stat_t q_stat;
  urfd_pkg::body_t       push_data;
  urfd_pkg::body_t       head;
  logic                  push;
  logic                  pop;

  urfd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rx_valid_i  (rx_valid_i),
    .rx_ready_o  (rx_ready_o),
    .rx_byte_i   (rx_byte_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .q_stat_i    (q_stat),
    .push_o      (push),
    .push_data_o (push_data)
  );

  urfd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .head_o      (head),
    .stat_o      (q_stat)
  );

  urfd_back u_back (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .q_stat_i            (q_stat),
    .head_i              (head),
    .pop_o               (pop),
    .res_valid_o         (res_valid_o),
    .res_ready_i         (res_ready_i),
    .command_code_o      (command_code_o),
    .status_code_o       (status_code_o),
    .param_status_o      (param_status_o),
    .payload_front_o     (payload_front_o),
    .payload_back_o      (payload_back_o),
    .received_checksum_o (received_checksum_o),
    .checksum_ok_o       (checksum_ok_o)
  );

endmodule

`default_nettype wire

[tb/sv/tb_uart_response_frame_deframer.sv]
`default_nettype none

module tb_uart_response_frame_deframer;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RAND_ITEMS    = 940;
  localparam int unsigned CFG_EVERY     = 300;
  localparam int unsigned HOLD_CYCLES   = 1000;
  localparam int unsigned DRAIN_CYCLES  = 8;
  localparam int unsigned CYCLE_LIMIT   = 400000;
  localparam int unsigned REPORT_LIMIT  = 10;
  localparam int unsigned NUM_DIR_ROWS  = 23;

  // Register index that decodes to no register
  localparam logic [urfd_pkg::CFG_IDX_W-1:0] CFG_IDX_UNUSED = 4'd9;

  typedef struct packed {
    logic [7:0]  command_code;
    logic [7:0]  status_code;
    logic [7:0]  param_status;
    logic [63:0] payload_front;
    logic [31:0] payload_back;
    logic [7:0]  received_checksum;
    logic        checksum_ok;
  } frame_result_t;

  typedef enum logic [3:0] {
    ROW_FRAME,        // header, 14 bytes of one fill value, given checksum, tail
    ROW_FRAME_RAND,   // good header, random body, correct checksum
    ROW_BAD_HEADER,   // complete frame with the wrong first byte
    ROW_SHORT,        // data random bytes, then a tail
    ROW_REPEAT,       // data[7:0] sent data[15:8] times
    ROW_CFG_HEADER,
    ROW_CFG_TAIL,
    ROW_CFG_UNKNOWN
  } row_kind_e;

  typedef struct packed {
    row_kind_e     kind;
    logic [31:0]   data;
    logic [7:0]    chk;
    logic          typed;
    frame_result_t exp;
  } dir_row_t;

  // Directed stimulus; typed expectations only for the obvious fill frames
  localparam dir_row_t DIR_ROWS [NUM_DIR_ROWS] = '{
    '{ROW_FRAME, 32'h00, 8'h00, 1'b1,
      '{8'h00, 8'h00, 8'h00, 64'h0, 32'h0, 8'h00, 1'b1}},
    '{ROW_FRAME, 32'hFF, 8'hFF, 1'b1,
      '{8'hFF, 8'hFF, 8'hFF, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF, 8'hFF, 1'b0}},
    '{ROW_FRAME, 32'h01, 8'h0E, 1'b1,
      '{8'h01, 8'h01, 8'h01, 64'h0101_0101_0101_0101, 32'h0101_0101, 8'h0E, 1'b1}},
    '{ROW_FRAME_RAND,  32'h0,          8'h00, 1'b0, '0},
    '{ROW_BAD_HEADER,  32'h0,          8'h00, 1'b0, '0},
    '{ROW_SHORT,       32'd6,          8'h00, 1'b0, '0},
    '{ROW_SHORT,       32'd0,          8'h00, 1'b0, '0},
    '{ROW_FRAME_RAND,  32'h0,          8'h00, 1'b0, '0},
    '{ROW_CFG_HEADER,  32'h00,         8'h00, 1'b0, '0},
    '{ROW_FRAME, 32'h00, 8'h00, 1'b1,
      '{8'h00, 8'h00, 8'h00, 64'h0, 32'h0, 8'h00, 1'b1}},
    '{ROW_CFG_HEADER,  32'hFF,         8'h00, 1'b0, '0},
    '{ROW_FRAME_RAND,  32'h0,          8'h00, 1'b0, '0},
    '{ROW_CFG_TAIL,    32'hFFFF_FFFF,  8'h00, 1'b0, '0},
    '{ROW_FRAME_RAND,  32'h0,          8'h00, 1'b0, '0},
    '{ROW_REPEAT,      32'h0000_03FF,  8'h00, 1'b0, '0},
    '{ROW_REPEAT,      32'h0000_01FF,  8'h00, 1'b0, '0},
    '{ROW_FRAME_RAND,  32'h0,          8'h00, 1'b0, '0},
    '{ROW_CFG_TAIL,    32'h0000_0000,  8'h00, 1'b0, '0},
    '{ROW_FRAME_RAND,  32'h0,          8'h00, 1'b0, '0},
    '{ROW_CFG_UNKNOWN, 32'h1234_5678,  8'h00, 1'b0, '0},
    '{ROW_CFG_TAIL,    urfd_pkg::TAIL_RESET, 8'h00, 1'b0, '0},
    '{ROW_CFG_HEADER,  {24'h0, urfd_pkg::HEADER_RESET}, 8'h00, 1'b0, '0},
    '{ROW_FRAME_RAND,  32'h0,          8'h00, 1'b0, '0}
  };

  logic                            clk;
  logic                            rst_n;
  logic                            rx_valid;
  logic                            rx_ready;
  logic [7:0]                      rx_byte;
  logic                            cfg_valid;
  logic                            cfg_ready;
  logic [urfd_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [urfd_pkg::CFG_DATA_W-1:0] cfg_data;
  logic                            res_valid;
  logic                            res_ready;
  frame_result_t                   dut_res;

  uart_response_frame_deframer dut (
    .clk_i               (clk),
    .rst_ni              (rst_n),
    .rx_valid_i          (rx_valid),
    .rx_ready_o          (rx_ready),
    .rx_byte_i           (rx_byte),
    .cfg_valid_i         (cfg_valid),
    .cfg_ready_o         (cfg_ready),
    .cfg_index_i         (cfg_index),
    .cfg_data_i          (cfg_data),
    .res_valid_o         (res_valid),
    .res_ready_i         (res_ready),
    .command_code_o      (dut_res.command_code),
    .status_code_o       (dut_res.status_code),
    .param_status_o      (dut_res.param_status),
    .payload_front_o     (dut_res.payload_front),
    .payload_back_o      (dut_res.payload_back),
    .received_checksum_o (dut_res.received_checksum),
    .checksum_ok_o       (dut_res.checksum_ok)
  );

  // Deframer mirror: register copies, byte window, count since boundary
  logic [7:0]  hdr_reg;
  logic [31:0] tail_reg;
  logic [7:0]  win [urfd_pkg::FRAME_BYTES];
  logic [4:0]  since_boundary;

  frame_result_t frame_results_q [$];
  frame_result_t typed_exp;
  bit            use_typed;
  bit            calm;
  bit            hold_off_req;
  int unsigned   byte_count;
  int unsigned   cycle_count;
  int unsigned   mismatches;
  int unsigned   stall_left;

  // Shift one byte into the mirror; returns 1 when a frame result is due
  function automatic bit deframe_byte(input logic [7:0] b, output frame_result_t r);
    logic [31:0] last4;
    logic [7:0]  sum;
    r = '0;
    for (int i = 0; i < urfd_pkg::FRAME_BYTES - 1; i++) win[i] = win[i+1];
    win[urfd_pkg::FRAME_BYTES-1] = b;
    if (since_boundary < urfd_pkg::FRAME_BYTES) since_boundary++;
    last4 = {win[16], win[17], win[18], win[19]};
    if (since_boundary < urfd_pkg::TAIL_BYTES || last4 != tail_reg) return 1'b0;
    // short frame resyncs, long enough moves the boundary
    if (since_boundary < urfd_pkg::FRAME_BYTES) begin
      since_boundary = '0;
      return 1'b0;
    end
    since_boundary = '0;
    if (win[0] != hdr_reg) return 1'b0;
    sum = '0;
    for (int i = 1; i <= 14; i++) sum += win[i];
    r.command_code      = win[1];
    r.status_code       = win[2];
    r.param_status      = win[14];
    for (int i = 2; i <= 9; i++) r.payload_front = {r.payload_front[55:0], win[i]};
    for (int i = 10; i <= 13; i++) r.payload_back = {r.payload_back[23:0], win[i]};
    r.received_checksum = win[15];
    r.checksum_ok       = (sum == win[15]);
    return 1'b1;
  endfunction

  // Mostly short gaps, a few long ones, none in calm stretches
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Cycle limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Result consumer: random stalls plus one long hold-off on request
  initial begin
    int unsigned g;
    res_ready  = 1'b0;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        res_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_off_req = 1'b0;
      end else if (stall_left > 0) begin
        res_ready <= 1'b0;
        stall_left--;
      end else begin
        g = ($urandom_range(0, 7) == 0) ? pick_gap() : 0;
        if (g > 0) begin
          res_ready  <= 1'b0;
          stall_left = g - 1;
        end else begin
          res_ready <= 1'b1;
        end
      end
    end
  end

  // Compare each result transaction with the oldest expectation
  always @(posedge clk) begin
    frame_result_t exp_res;
    if (rst_n && res_valid && res_ready) begin
      if (frame_results_q.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("unexpected result: cmd=%h sts=%h par=%h front=%h back=%h chk=%h ok=%b",
                   dut_res.command_code, dut_res.status_code, dut_res.param_status,
                   dut_res.payload_front, dut_res.payload_back,
                   dut_res.received_checksum, dut_res.checksum_ok);
      end else begin
        exp_res = frame_results_q.pop_front();
        if (dut_res.command_code !== exp_res.command_code ||
            dut_res.status_code !== exp_res.status_code ||
            dut_res.param_status !== exp_res.param_status ||
            dut_res.payload_front !== exp_res.payload_front ||
            dut_res.payload_back !== exp_res.payload_back ||
            dut_res.received_checksum !== exp_res.received_checksum ||
            dut_res.checksum_ok !== exp_res.checksum_ok) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT) begin
            $display("mismatch exp: cmd=%h sts=%h par=%h front=%h back=%h chk=%h ok=%b",
                     exp_res.command_code, exp_res.status_code, exp_res.param_status,
                     exp_res.payload_front, exp_res.payload_back,
                     exp_res.received_checksum, exp_res.checksum_ok);
            $display("         got: cmd=%h sts=%h par=%h front=%h back=%h chk=%h ok=%b",
                     dut_res.command_code, dut_res.status_code, dut_res.param_status,
                     dut_res.payload_front, dut_res.payload_back,
                     dut_res.received_checksum, dut_res.checksum_ok);
          end
        end
      end
    end
  end

  // One rx transaction, then an optional gap
  task automatic send_byte(input logic [7:0] b);
    frame_result_t r;
    bit            hit;
    int unsigned   g;
    @(negedge clk);
    rx_valid <= 1'b1;
    rx_byte  <= b;
    do @(posedge clk); while (!rx_ready);
    hit = deframe_byte(b, r);
    if (hit) frame_results_q.push_back(use_typed ? typed_exp : r);
    byte_count++;
    g = pick_gap();
    if (g > 0) begin
      @(negedge clk);
      rx_valid <= 1'b0;
      repeat (g - 1) @(negedge clk);
    end
  endtask

  task automatic send_tail(input int unsigned n);
    for (int i = 0; i < n; i++) send_byte(tail_reg[31 - 8*i -: 8]);
  endtask

  task automatic send_frame(input logic [7:0] hdr, input logic [13:0][7:0] body,
                            input logic [7:0] chk);
    send_byte(hdr);
    for (int i = 0; i < 14; i++) send_byte(body[i]);
    send_byte(chk);
    send_tail(urfd_pkg::TAIL_BYTES);
  endtask

  task automatic random_frame(input logic [7:0] hdr, input bit good_sum);
    logic [13:0][7:0] body;
    logic [7:0]       sum;
    sum = '0;
    for (int i = 0; i < 14; i++) begin
      body[i] = $urandom_range(0, 255);
      sum += body[i];
    end
    send_frame(hdr, body, good_sum ? sum : 8'($urandom_range(0, 255)));
  endtask

  task automatic stop_rx();
    if (rx_valid) begin
      @(negedge clk);
      rx_valid <= 1'b0;
    end
  endtask

  // Block idle: every result in, then a drain wait for a frame with no result
  task automatic wait_idle();
    while (frame_results_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [urfd_pkg::CFG_IDX_W-1:0] idx,
                           input logic [31:0] value);
    stop_rx();
    wait_idle();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      urfd_pkg::CFG_EXPECTED_HEADER: hdr_reg = value[7:0];
      urfd_pkg::CFG_TAIL_PATTERN:    tail_reg = value;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Stimulus
  initial begin
    dir_row_t    row;
    int unsigned rand_start;
    int unsigned next_cfg_at;
    int unsigned op;
    logic [31:0] pick;

    rst_n        = 1'b0;
    rx_valid     = 1'b0;
    rx_byte      = '0;
    cfg_valid    = 1'b0;
    cfg_index    = '0;
    cfg_data     = '0;
    use_typed    = 1'b0;
    typed_exp    = '0;
    calm         = 1'b0;
    hold_off_req = 1'b0;
    byte_count   = 0;
    cycle_count  = 0;
    mismatches   = 0;
    hdr_reg        = urfd_pkg::HEADER_RESET;
    tail_reg       = urfd_pkg::TAIL_RESET;
    since_boundary = '0;
    for (int i = 0; i < urfd_pkg::FRAME_BYTES; i++) win[i] = '0;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed table
    for (int n = 0; n < NUM_DIR_ROWS; n++) begin
      row = DIR_ROWS[n];
      case (row.kind)
        ROW_FRAME: begin
          use_typed = row.typed;
          typed_exp = row.exp;
          send_frame(hdr_reg, {14{row.data[7:0]}}, row.chk);
          use_typed = 1'b0;
        end
        ROW_FRAME_RAND:  random_frame(hdr_reg, 1'b1);
        ROW_BAD_HEADER:  random_frame(~hdr_reg, 1'b1);
        ROW_SHORT: begin
          repeat (row.data) send_byte($urandom_range(0, 255));
          send_tail(urfd_pkg::TAIL_BYTES);
        end
        ROW_REPEAT:      repeat (row.data[15:8]) send_byte(row.data[7:0]);
        ROW_CFG_HEADER:  write_reg(urfd_pkg::CFG_EXPECTED_HEADER, row.data);
        ROW_CFG_TAIL:    write_reg(urfd_pkg::CFG_TAIL_PATTERN, row.data);
        ROW_CFG_UNKNOWN: write_reg(CFG_IDX_UNUSED, row.data);
        default: ;
      endcase
    end

    // Random traffic, mostly well-formed frames; long consumer hold-off first
    rand_start   = byte_count;
    next_cfg_at  = byte_count + CFG_EVERY;
    hold_off_req = 1'b1;
    while (byte_count - rand_start < RAND_ITEMS) begin
      if (byte_count >= next_cfg_at) begin
        calm = 1'b0;
        case ($urandom_range(0, 3))
          0:       pick = 32'h00;
          1:       pick = 32'hFF;
          2:       pick = {24'h0, urfd_pkg::HEADER_RESET};
          default: pick = $urandom_range(0, 255);
        endcase
        write_reg(urfd_pkg::CFG_EXPECTED_HEADER, pick);
        case ($urandom_range(0, 3))
          0:       pick = urfd_pkg::TAIL_RESET;
          1:       pick = 32'hFFFF_FFFF;
          2:       pick = 32'h0000_0000;
          default: pick = $urandom;
        endcase
        write_reg(urfd_pkg::CFG_TAIL_PATTERN, pick);
        if ($urandom_range(0, 3) == 0) write_reg(CFG_IDX_UNUSED, $urandom);
        next_cfg_at = byte_count + CFG_EVERY;
      end
      calm = ($urandom_range(0, 9) == 0);
      op   = $urandom_range(0, 99);
      if (op < 65) begin
        random_frame(($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255)) : hdr_reg,
                     $urandom_range(0, 3) != 0);
      end else if (op < 75) begin
        // short frame
        repeat ($urandom_range(0, 15)) send_byte($urandom_range(0, 255));
        send_tail(urfd_pkg::TAIL_BYTES);
      end else if (op < 85) begin
        repeat ($urandom_range(1, 6)) send_byte($urandom_range(0, 255));
      end else if (op < 92) begin
        // partial tail
        send_tail($urandom_range(1, 3));
      end else begin
        random_frame(hdr_reg ^ 8'($urandom_range(1, 255)), 1'b1);
      end
    end
    calm = 1'b0;

    // Drain and report
    stop_rx();
    wait_idle();
    if (mismatches == 0 && frame_results_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

[files.f]
rtl/urfd_pkg.sv
rtl/urfd_queue.sv
rtl/urfd_front.sv
rtl/urfd_back.sv
rtl/uart_response_frame_deframer.sv
tb/sv/tb_uart_response_frame_deframer.sv
